>>> rtl/core/kst_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kst_pkg
// Shared sizes, codes and interface types of the keyed slot table.
// ----------------------------------------------------------------------------
package kst_pkg;

   localparam int SLOTS      = 16;
   localparam int CODE_BITS  = 16;
   localparam int DATA_BITS  = 32;
   localparam int SLOT_BITS  = $clog2(SLOTS);
   localparam int COUNT_BITS = $clog2(SLOTS + 1);
   localparam int REQ_BITS   = 2;
   localparam int STAT_BITS  = 2;

   typedef enum logic [REQ_BITS-1:0] {
      REQ_DEPOSIT = 2'd0,
      REQ_REMOVE  = 2'd1,
      REQ_VIEW    = 2'd2,
      REQ_EXTRACT = 2'd3
   } req_code_type;

   typedef enum logic [STAT_BITS-1:0] {
      STAT_OK    = 2'd0,
      STAT_MISS  = 2'd1,
      STAT_FULL  = 2'd2,
      STAT_EMPTY = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_SCAN = 3'b010,
      ST_RESP = 3'b100
   } state_type;

   typedef struct packed {
      logic [SLOT_BITS-1:0] rd_addr;
      logic                 wr_en;
      logic                 clr_en;
      logic [SLOT_BITS-1:0] wr_addr;
      logic [CODE_BITS-1:0] wr_code;
      logic [DATA_BITS-1:0] wr_data;
   } mem_cmd_type;

   typedef struct packed {
      logic                 valid;
      logic [CODE_BITS-1:0] code;
      logic [DATA_BITS-1:0] data;
   } mem_rd_type;

endpackage

>>> rtl/core/keyed_slot_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyed_slot_table
// Flow: a request on a full (deposit) or empty (other) table is answered
//   without a scan; otherwise the slots are scanned one per cycle through the
//   memory read port and compare unit up to the first hit or the last slot,
//   and the registered answer is held until it is transferred.
// Throughput: one request at a time, none taken until its answer transfers.
// Reset: all slots invalid, count zero; code and payload memory not cleared.
// ----------------------------------------------------------------------------
module keyed_slot_table
   import kst_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [REQ_BITS-1:0]   req_type,
   input  logic [CODE_BITS-1:0]  req_item_code,
   input  logic [DATA_BITS-1:0]  req_item_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [STAT_BITS-1:0]  rsp_status,
   output logic [CODE_BITS-1:0]  rsp_out_code,
   output logic [DATA_BITS-1:0]  rsp_out_data,
   output logic [SLOT_BITS-1:0]  rsp_slot_index,
   output logic [COUNT_BITS-1:0] rsp_occupied,
   output logic                  rsp_is_empty,
   output logic                  rsp_is_full
);

   mem_cmd_type mem_cmd;
   mem_rd_type  mem_rd;

   kst_slot_mem u_slot_mem (
      .clock   (clock),
      .reset   (reset),
      .mem_cmd (mem_cmd),
      .mem_rd  (mem_rd)
   );

   kst_scan u_scan (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_type       (req_type),
      .req_item_code  (req_item_code),
      .req_item_data  (req_item_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_status     (rsp_status),
      .rsp_out_code   (rsp_out_code),
      .rsp_out_data   (rsp_out_data),
      .rsp_slot_index (rsp_slot_index),
      .rsp_occupied   (rsp_occupied),
      .rsp_is_empty   (rsp_is_empty),
      .rsp_is_full    (rsp_is_full),
      .mem_cmd        (mem_cmd),
      .mem_rd         (mem_rd)
   );

endmodule

>>> rtl/core/kst_slot_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kst_slot_mem
// Slot storage: valid flags in flip-flops, code and payload in a memory
// with one write port and one registered read port.
// ----------------------------------------------------------------------------
module kst_slot_mem
   import kst_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  mem_cmd_type mem_cmd,
   output mem_rd_type  mem_rd
);

   logic [SLOTS-1:0]     valid_ff;
   logic [SLOTS-1:0]     valid_in;
   logic [CODE_BITS-1:0] code_mem [SLOTS];
   logic [DATA_BITS-1:0] data_mem [SLOTS];
   logic                 rd_valid_ff;
   logic [CODE_BITS-1:0] rd_code_ff;
   logic [DATA_BITS-1:0] rd_data_ff;

   always_comb begin
      valid_in = valid_ff;
      if (mem_cmd.wr_en) begin
         valid_in[mem_cmd.wr_addr] = 1'b1;
      end else if (mem_cmd.clr_en) begin
         valid_in[mem_cmd.wr_addr] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_cmd.wr_en) begin
         code_mem[mem_cmd.wr_addr] <= mem_cmd.wr_code;
         data_mem[mem_cmd.wr_addr] <= mem_cmd.wr_data;
      end
      rd_code_ff  <= code_mem[mem_cmd.rd_addr];
      rd_data_ff  <= data_mem[mem_cmd.rd_addr];
      rd_valid_ff <= valid_ff[mem_cmd.rd_addr];
   end

   assign mem_rd.valid = rd_valid_ff;
   assign mem_rd.code  = rd_code_ff;
   assign mem_rd.data  = rd_data_ff;

endmodule

>>> rtl/core/kst_scan.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kst_scan
// Request sequencer: walks the slots one per cycle through a single
// compare unit, stops at the first hit, updates the table and the count,
// and holds the result until it is transferred.
// ----------------------------------------------------------------------------
module kst_scan
   import kst_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [REQ_BITS-1:0]   req_type,
   input  logic [CODE_BITS-1:0]  req_item_code,
   input  logic [DATA_BITS-1:0]  req_item_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [STAT_BITS-1:0]  rsp_status,
   output logic [CODE_BITS-1:0]  rsp_out_code,
   output logic [DATA_BITS-1:0]  rsp_out_data,
   output logic [SLOT_BITS-1:0]  rsp_slot_index,
   output logic [COUNT_BITS-1:0] rsp_occupied,
   output logic                  rsp_is_empty,
   output logic                  rsp_is_full,
   output mem_cmd_type           mem_cmd,
   input  mem_rd_type            mem_rd
);

   state_type             state_ff, state_in;
   req_code_type          type_ff, type_in;
   logic [CODE_BITS-1:0]  key_ff, key_in;
   logic [DATA_BITS-1:0]  data_ff, data_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic [COUNT_BITS-1:0] issue_ff, issue_in;
   logic                  chk_vld_ff, chk_vld_in;
   logic [SLOT_BITS-1:0]  chk_idx_ff, chk_idx_in;
   status_type            rsp_status_ff, rsp_status_in;
   logic [CODE_BITS-1:0]  rsp_code_ff, rsp_code_in;
   logic [DATA_BITS-1:0]  rsp_data_ff, rsp_data_in;
   logic [SLOT_BITS-1:0]  rsp_idx_ff, rsp_idx_in;
   logic [COUNT_BITS-1:0] rsp_occ_ff, rsp_occ_in;
   logic                  rsp_empty_ff, rsp_empty_in;
   logic                  rsp_full_ff, rsp_full_in;
   logic                  hit;
   logic                  last;
   logic                  issue_more;
   logic                  resp_load;

   always_comb begin
      case (type_ff)
         REQ_DEPOSIT: hit = !mem_rd.valid;
         REQ_EXTRACT: hit = mem_rd.valid;
         default:     hit = mem_rd.valid && (mem_rd.code == key_ff);
      endcase
   end

   assign last       = chk_idx_ff == SLOT_BITS'(SLOTS - 1);
   assign issue_more = issue_ff < COUNT_BITS'(SLOTS);

   always_comb begin
      state_in      = state_ff;
      type_in       = type_ff;
      key_in        = key_ff;
      data_in       = data_ff;
      count_in      = count_ff;
      issue_in      = issue_ff;
      chk_vld_in    = chk_vld_ff;
      chk_idx_in    = chk_idx_ff;
      rsp_status_in = rsp_status_ff;
      rsp_code_in   = rsp_code_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_idx_in    = rsp_idx_ff;
      rsp_occ_in    = rsp_occ_ff;
      rsp_empty_in  = rsp_empty_ff;
      rsp_full_in   = rsp_full_ff;
      resp_load     = 1'b0;

      mem_cmd         = '0;
      mem_cmd.rd_addr = issue_ff[SLOT_BITS-1:0];
      mem_cmd.wr_addr = chk_idx_ff;
      mem_cmd.wr_code = key_ff;
      mem_cmd.wr_data = data_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               type_in     = req_code_type'(req_type);
               key_in      = req_item_code;
               data_in     = req_item_data;
               issue_in    = '0;
               chk_vld_in  = 1'b0;
               rsp_code_in = '0;
               rsp_data_in = '0;
               rsp_idx_in  = '0;
               if (req_code_type'(req_type) == REQ_DEPOSIT &&
                   count_ff == COUNT_BITS'(SLOTS)) begin
                  rsp_status_in = STAT_FULL;
                  resp_load     = 1'b1;
                  state_in      = ST_RESP;
               end else if (req_code_type'(req_type) != REQ_DEPOSIT &&
                            count_ff == '0) begin
                  rsp_status_in = STAT_EMPTY;
                  resp_load     = 1'b1;
                  state_in      = ST_RESP;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            issue_in   = issue_more ? issue_ff + COUNT_BITS'(1) : issue_ff;
            chk_vld_in = issue_more;
            chk_idx_in = issue_ff[SLOT_BITS-1:0];
            if (chk_vld_ff && hit) begin
               rsp_status_in = STAT_OK;
               rsp_idx_in    = chk_idx_ff;
               resp_load     = 1'b1;
               state_in      = ST_RESP;
               case (type_ff)
                  REQ_DEPOSIT: begin
                     mem_cmd.wr_en = 1'b1;
                     count_in      = count_ff + COUNT_BITS'(1);
                  end
                  REQ_REMOVE: begin
                     mem_cmd.clr_en = 1'b1;
                     count_in       = count_ff - COUNT_BITS'(1);
                  end
                  REQ_VIEW: begin
                     rsp_code_in = mem_rd.code;
                     rsp_data_in = mem_rd.data;
                  end
                  default: begin
                     mem_cmd.clr_en = 1'b1;
                     count_in       = count_ff - COUNT_BITS'(1);
                     rsp_code_in    = mem_rd.code;
                     rsp_data_in    = mem_rd.data;
                  end
               endcase
            end else if (chk_vld_ff && last) begin
               resp_load = 1'b1;
               state_in  = ST_RESP;
               case (type_ff)
                  REQ_DEPOSIT: rsp_status_in = STAT_FULL;
                  REQ_EXTRACT: rsp_status_in = STAT_EMPTY;
                  default:     rsp_status_in = STAT_MISS;
               endcase
            end
         end
         ST_RESP: begin
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (resp_load) begin
         rsp_occ_in   = count_in;
         rsp_empty_in = count_in == '0;
         rsp_full_in  = count_in == COUNT_BITS'(SLOTS);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         count_ff   <= '0;
         chk_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         chk_vld_ff <= chk_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      type_ff       <= type_in;
      key_ff        <= key_in;
      data_ff       <= data_in;
      issue_ff      <= issue_in;
      chk_idx_ff    <= chk_idx_in;
      rsp_status_ff <= rsp_status_in;
      rsp_code_ff   <= rsp_code_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_idx_ff    <= rsp_idx_in;
      rsp_occ_ff    <= rsp_occ_in;
      rsp_empty_ff  <= rsp_empty_in;
      rsp_full_ff   <= rsp_full_in;
   end

   assign req_ready      = state_ff == ST_IDLE;
   assign rsp_valid      = state_ff == ST_RESP;
   assign rsp_status     = rsp_status_ff;
   assign rsp_out_code   = rsp_code_ff;
   assign rsp_out_data   = rsp_data_ff;
   assign rsp_slot_index = rsp_idx_ff;
   assign rsp_occupied   = rsp_occ_ff;
   assign rsp_is_empty   = rsp_empty_ff;
   assign rsp_is_full    = rsp_full_ff;

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_BITS'(SLOTS))
      else $error("slot count exceeds table size");

   a_idx_on_error: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RESP && rsp_status_ff != STAT_OK) |-> rsp_idx_ff == '0)
      else $error("slot index nonzero on failed request");

   a_write_not_full: assert property (@(posedge clock) disable iff (reset)
      mem_cmd.wr_en |-> count_ff < COUNT_BITS'(SLOTS))
      else $error("deposit write into full table");

   a_clear_not_empty: assert property (@(posedge clock) disable iff (reset)
      mem_cmd.clr_en |-> count_ff != '0)
      else $error("slot clear on empty table");

   a_full_shortcut: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE && req_valid && req_type == REQ_DEPOSIT &&
       count_ff == COUNT_BITS'(SLOTS))
      |=> (state_ff == ST_RESP && rsp_status_ff == STAT_FULL))
      else $error("deposit on full table not rejected");

endmodule

>>> verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Regression for the keyed slot table. Requests go in over the req_ channel
// with random gaps, while results are taken off the rsp_ channel with random
// stalls and one long hold-off. A mirror of the slot table predicts each
// result at its request's transfer, and every result is checked field by field in order.
// ----------------------------------------------------------------------------
module tb;
   import kst_pkg::*;

   typedef struct packed {
      status_type             status;
      logic [CODE_BITS-1:0]   code;
      logic [DATA_BITS-1:0]   data;
      logic [SLOT_BITS-1:0]   slot;
      logic [COUNT_BITS-1:0]  occupied;
      logic                   is_empty;
      logic                   is_full;
   } answer_type;

   logic                  clock;
   logic                  reset         = 1'b1;
   logic                  req_valid     = 1'b0;
   logic                  req_ready;
   logic [REQ_BITS-1:0]   req_type      = REQ_DEPOSIT;
   logic [CODE_BITS-1:0]  req_item_code = '0;
   logic [DATA_BITS-1:0]  req_item_data = '0;
   logic                  rsp_valid;
   logic                  rsp_ready     = 1'b0;
   logic [STAT_BITS-1:0]  rsp_status;
   logic [CODE_BITS-1:0]  rsp_out_code;
   logic [DATA_BITS-1:0]  rsp_out_data;
   logic [SLOT_BITS-1:0]  rsp_slot_index;
   logic [COUNT_BITS-1:0] rsp_occupied;
   logic                  rsp_is_empty;
   logic                  rsp_is_full;

   // mirror of the slot table
   logic [SLOTS-1:0]      mirror_live;
   logic [CODE_BITS-1:0]  mirror_code [SLOTS];
   logic [DATA_BITS-1:0]  mirror_data [SLOTS];
   int                    mirror_count;

   answer_type            pending_answers[$];
   int                    error_count   = 0;

   int                    send_gap_pct  = 0;
   int                    rsp_stall_pct = 0;
   int                    hold_len      = 0;
   int                    hold_order    = 0;
   int                    hold_taken    = 0;
   int                    hold_left     = 0;

   keyed_slot_table u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_type       (req_type),
      .req_item_code  (req_item_code),
      .req_item_data  (req_item_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_status     (rsp_status),
      .rsp_out_code   (rsp_out_code),
      .rsp_out_data   (rsp_out_data),
      .rsp_slot_index (rsp_slot_index),
      .rsp_occupied   (rsp_occupied),
      .rsp_is_empty   (rsp_is_empty),
      .rsp_is_full    (rsp_is_full)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #1_000_000;
      $display("keyed_slot_table regression: fail");
      $finish;
   end

   function automatic answer_type predict_answer(input req_code_type kind,
                                                 input logic [CODE_BITS-1:0] key,
                                                 input logic [DATA_BITS-1:0] word);
      answer_type ans;
      int         hit;
      ans  = '0;
      hit  = -1;
      ans.status = STAT_OK;
      if (kind == REQ_DEPOSIT) begin
         for (int i = SLOTS - 1; i >= 0; i--)
            if (!mirror_live[i]) hit = i;
         if (mirror_count >= SLOTS || hit < 0) begin
            ans.status = STAT_FULL;
         end else begin
            mirror_live[hit] = 1'b1;
            mirror_code[hit] = key;
            mirror_data[hit] = word;
            mirror_count++;
         end
      end else if (mirror_count == 0) begin
         ans.status = STAT_EMPTY;
      end else if (kind == REQ_EXTRACT) begin
         for (int i = SLOTS - 1; i >= 0; i--)
            if (mirror_live[i]) hit = i;
         if (hit < 0) begin
            ans.status = STAT_EMPTY;
         end else begin
            ans.code = mirror_code[hit];
            ans.data = mirror_data[hit];
            mirror_live[hit] = 1'b0;
            mirror_count--;
         end
      end else begin
         for (int i = SLOTS - 1; i >= 0; i--)
            if (mirror_live[i] && mirror_code[i] == key) hit = i;
         if (hit < 0) begin
            ans.status = STAT_MISS;
         end else if (kind == REQ_REMOVE) begin
            mirror_live[hit] = 1'b0;
            mirror_count--;
         end else begin
            ans.code = mirror_code[hit];
            ans.data = mirror_data[hit];
         end
      end
      if (ans.status == STAT_OK) ans.slot = hit[SLOT_BITS-1:0];
      ans.occupied = mirror_count[COUNT_BITS-1:0];
      ans.is_empty = (mirror_count == 0);
      ans.is_full  = (mirror_count >= SLOTS);
      return ans;
   endfunction

   function automatic void check_field(input string name, input logic [DATA_BITS-1:0] due,
                                       input logic [DATA_BITS-1:0] got);
      if (got !== due) begin
         $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, due, got);
         error_count++;
      end
   endfunction

   // check each result transfer, then predict each request transfer
   always @(posedge clock) begin
      answer_type due;
      if (reset) begin
         mirror_live  = '0;
         mirror_count = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (pending_answers.size() == 0) begin
               $display("%0t: unexpected result, expected none actual status %0d code %0h data %0h",
                        $time, rsp_status, rsp_out_code, rsp_out_data);
               error_count++;
            end else begin
               due = pending_answers.pop_front();
               check_field("status",     DATA_BITS'(due.status),   DATA_BITS'(rsp_status));
               check_field("out_code",   DATA_BITS'(due.code),     DATA_BITS'(rsp_out_code));
               check_field("out_data",   due.data,                 rsp_out_data);
               check_field("slot_index", DATA_BITS'(due.slot),     DATA_BITS'(rsp_slot_index));
               check_field("occupied",   DATA_BITS'(due.occupied), DATA_BITS'(rsp_occupied));
               check_field("is_empty",   DATA_BITS'(due.is_empty), DATA_BITS'(rsp_is_empty));
               check_field("is_full",    DATA_BITS'(due.is_full),  DATA_BITS'(rsp_is_full));
            end
         end
         if (req_valid && req_ready)
            pending_answers.push_back(predict_answer(req_code_type'(req_type),
                                                     req_item_code, req_item_data));
      end
   end

   // result side: random stalls, plus a long hold-off on request
   always @(posedge clock) begin
      if (hold_order != hold_taken) begin
         hold_taken = hold_order;
         hold_left  = hold_len;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   task automatic send_request(input req_code_type kind, input logic [CODE_BITS-1:0] key,
                               input logic [DATA_BITS-1:0] word);
      if ($urandom_range(99) < send_gap_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_gap_pct);
      end
      req_valid     <= 1'b1;
      req_type      <= kind;
      req_item_code <= key;
      req_item_data <= word;
      do @(posedge clock); while (!req_ready);
   endtask

   // first wait on a clock edge so the last request transfer is already queued
   task automatic wait_for_answers();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_answers.size() != 0) @(posedge clock);
   endtask

   task automatic test_empty_table();
      send_request(REQ_REMOVE,  '0,           '0);
      send_request(REQ_VIEW,    '1,           '1);
      send_request(REQ_EXTRACT, 16'h5A5A,     32'hA5A5_A5A5);
      wait_for_answers();
   endtask

   task automatic test_basic_ops();
      send_gap_pct  = 30;
      rsp_stall_pct = 30;
      send_request(REQ_DEPOSIT, '0,       '0);
      send_request(REQ_DEPOSIT, '1,       '1);
      send_request(REQ_DEPOSIT, 16'h55AA, 32'hAAAA_5555);
      send_request(REQ_VIEW,    '1,       '0);
      send_request(REQ_VIEW,    '0,       '1);
      send_request(REQ_VIEW,    16'h1234, '0);
      send_request(REQ_REMOVE,  16'h1234, '0);
      send_request(REQ_REMOVE,  '0,       '0);
      send_request(REQ_DEPOSIT, '1,       32'h0000_0005);
      send_request(REQ_VIEW,    '1,       '0);
      send_request(REQ_REMOVE,  '1,       '0);
      send_request(REQ_EXTRACT, '0,       '0);
      send_request(REQ_EXTRACT, '0,       '0);
      send_request(REQ_EXTRACT, '0,       '0);
      wait_for_answers();
   endtask

   // hold the result side so the table fills while requests back up
   task automatic test_fill_under_backpressure();
      send_gap_pct  = 0;
      rsp_stall_pct = 0;
      hold_len      = 300;
      hold_order++;
      for (int i = 0; i <= SLOTS; i++)
         send_request(REQ_DEPOSIT, CODE_BITS'(i), $urandom);
      send_request(REQ_VIEW,    CODE_BITS'(5),     '0);
      send_request(REQ_REMOVE,  CODE_BITS'(SLOTS), '0);
      send_request(REQ_REMOVE,  CODE_BITS'(3),     '0);
      send_request(REQ_EXTRACT, '0,                '0);
      send_request(REQ_DEPOSIT, 16'hFFFF,          $urandom);
      send_request(REQ_DEPOSIT, 16'hFFFF,          $urandom);
      wait_for_answers();
   endtask

   task automatic test_random_traffic(input int gap_pct, input int stall_pct, input int items);
      logic [CODE_BITS-1:0] key_pool [8];
      logic [CODE_BITS-1:0] key;
      req_code_type         kind;
      bit                   filling;
      send_gap_pct  = gap_pct;
      rsp_stall_pct = stall_pct;
      filling       = 1'b0;
      key_pool[0]   = '0;
      key_pool[1]   = '1;
      for (int i = 2; i < 8; i++) key_pool[i] = CODE_BITS'($urandom);
      for (int n = 0; n < items; n++) begin
         if (n % 48 == 0) filling = !filling;
         if ($urandom_range(99) < (filling ? 70 : 15))
            kind = REQ_DEPOSIT;
         else
            kind = req_code_type'($urandom_range(3, 1));
         if ($urandom_range(9) < 7)
            key = key_pool[$urandom_range(7)];
         else
            key = CODE_BITS'($urandom);
         send_request(kind, key, $urandom);
      end
      wait_for_answers();
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      test_empty_table();
      test_basic_ops();
      test_fill_under_backpressure();
      test_random_traffic(0,  0,  200);
      test_random_traffic(53, 0,  200);
      test_random_traffic(0,  53, 200);
      test_random_traffic(25, 25, 200);
      repeat (SLOTS + 8) @(posedge clock);
      if (error_count == 0 && pending_answers.size() == 0)
         $display("keyed_slot_table regression: pass");
      else
         $display("keyed_slot_table regression: fail");
      $finish;
   end

endmodule
